// ===== src/rpu_pkg.sv =====
// Shared types, constants and conversion functions for the raw PCM unpacker.
`timescale 1ns / 1ps
package rpu_pkg;

  // Queue between the framing front end and the result back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 1;

  // Offset-binary samples become two's complement by flipping the top bit.
  localparam logic [15:0] SIGN_FLIP = 16'h8000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SIXTEEN_BIT     = 3'd0,
    REG_SIGNED_SAMPLES  = 3'd1,
    REG_STEREO_MODE     = 3'd2,
    REG_BIG_ENDIAN      = 3'd3,
    REG_SKIP_FIRST_BYTE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic sixteen_bit;
    logic signed_samples;
    logic stereo_mode;
    logic big_endian;
    logic skip_first_byte;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       block_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] sample;
    logic               channel;
    logic               frame_last;
  } out_item_t;

  // One finished frame: a mono sample, or a left/right pair.
  typedef struct packed {
    logic        pair;
    logic [15:0] first;
    logic [15:0] second;
  } entry_t;

  function automatic logic [15:0] conv8(input logic [7:0] b, input logic is_signed);
    logic [15:0] v;
    v = {b, 8'h00};
    if (!is_signed) begin
      v = v ^ SIGN_FLIP;
    end
    return v;
  endfunction

  function automatic logic [15:0] conv16(input logic [7:0] first_b, input logic [7:0] second_b,
                                         input logic big, input logic is_signed);
    logic [15:0] v;
    v = big ? {first_b, second_b} : {second_b, first_b};
    if (!is_signed) begin
      v = v ^ SIGN_FLIP;
    end
    return v;
  endfunction

endpackage

// ===== src/rpu_front.sv =====
// Front end: byte framing, skip handling and sample assembly.
`timescale 1ns / 1ps
module rpu_front (
  input  logic              clk,
  input  logic              rst,
  input  rpu_pkg::cfg_t     cfg,
  input  logic              accept,
  input  rpu_pkg::in_item_t item,
  output logic              entry_valid,
  output rpu_pkg::entry_t   entry
);

  logic [7:0]  pending_byte, pending_byte_next;
  logic [1:0]  frame_position, frame_position_next;
  logic [15:0] held_left, held_left_next;
  logic        skip_armed, skip_armed_next;

  logic        skip_now;
  logic [1:0]  pos;
  logic [15:0] s8;
  logic [15:0] s16;

  always_comb begin
    // A block start clears framing and, in 16-bit mode with the skip set, skips this very byte.
    skip_now = item.block_start ? (cfg.skip_first_byte & cfg.sixteen_bit) : skip_armed;
    pos      = item.block_start ? 2'd0 : frame_position;
    s8       = rpu_pkg::conv8(item.data_byte, cfg.signed_samples);
    s16      = rpu_pkg::conv16(pending_byte, item.data_byte, cfg.big_endian,
                               cfg.signed_samples);

    pending_byte_next   = pending_byte;
    frame_position_next = frame_position;
    held_left_next      = held_left;
    skip_armed_next     = skip_armed;
    entry_valid         = 1'b0;
    entry.pair          = 1'b0;
    entry.first         = s8;
    entry.second        = s8;

    if (accept) begin
      skip_armed_next     = 1'b0;
      frame_position_next = pos;
      if (!skip_now) begin
        priority if (!cfg.sixteen_bit && !cfg.stereo_mode) begin
          frame_position_next = 2'd0;
          entry_valid         = 1'b1;
        end else if (!cfg.sixteen_bit) begin
          if (pos == 2'd0) begin
            held_left_next      = s8;
            frame_position_next = 2'd1;
          end else begin
            frame_position_next = 2'd0;
            entry_valid         = 1'b1;
            entry.pair          = 1'b1;
            entry.first         = held_left;
          end
        end else if (!cfg.stereo_mode) begin
          if (!pos[0]) begin
            pending_byte_next   = item.data_byte;
            frame_position_next = 2'd1;
          end else begin
            frame_position_next = 2'd0;
            entry_valid         = 1'b1;
            entry.first         = s16;
          end
        end else begin
          unique case (pos)
            2'd0: begin
              pending_byte_next   = item.data_byte;
              frame_position_next = 2'd1;
            end
            2'd1: begin
              held_left_next      = s16;
              frame_position_next = 2'd2;
            end
            2'd2: begin
              pending_byte_next   = item.data_byte;
              frame_position_next = 2'd3;
            end
            default: begin
              frame_position_next = 2'd0;
              entry_valid         = 1'b1;
              entry.pair          = 1'b1;
              entry.first         = held_left;
              entry.second        = s16;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_byte   <= '0;
      frame_position <= '0;
      held_left      <= '0;
      skip_armed     <= 1'b0;
    end else begin
      pending_byte   <= pending_byte_next;
      frame_position <= frame_position_next;
      held_left      <= held_left_next;
      skip_armed     <= skip_armed_next;
    end
  end

endmodule

// ===== src/rpu_queue.sv =====
// Small register queue of finished frames between front and back end.
`timescale 1ns / 1ps
module rpu_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  rpu_pkg::entry_t wr_data,
  input  logic            rd_en,
  output rpu_pkg::entry_t rd_data,
  output logic            q_full,
  output logic            q_empty
);

  rpu_pkg::entry_t              slots [rpu_pkg::QDEPTH];
  logic [rpu_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rpu_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rpu_pkg::QPTR_W:0]     count;

  assign q_full  = (count == (rpu_pkg::QPTR_W+1)'(rpu_pkg::QDEPTH));
  assign q_empty = (count == '0);
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/rpu_back.sv =====
// Back end: splits each queued frame into one or two result items.
`timescale 1ns / 1ps
module rpu_back (
  input  logic               clk,
  input  logic               rst,
  input  rpu_pkg::entry_t    head,
  input  logic               head_empty,
  input  logic               pop,
  output logic               head_done,
  output logic               empty,
  output rpu_pkg::out_item_t result
);

  // Set while the left half of a pair has gone and the right one is shown.
  logic phase;
  logic take;

  assign empty     = head_empty;
  assign take      = pop & ~head_empty;
  assign head_done = take & (~head.pair | phase);

  assign result.sample     = (head.pair & phase) ? head.second : head.first;
  assign result.channel    = head.pair & phase;
  assign result.frame_last = ~head.pair | phase;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (take) begin
      phase <= head.pair & ~phase;
    end
  end

endmodule

// ===== src/raw_pcm_unpacker.sv =====
// Top level of the raw PCM unpacker: config registers, front end, queue, back end.
`timescale 1ns / 1ps
//
//  channel   handshake          payload        direction
//  -------   ---------------    ------------   ---------
//  item      push / full        in_item_t      in   (one raw byte + block start flag)
//  result    empty / pop        out_item_t     out  (Q15 sample, channel, frame_last)
//  config    cfg_write          cfg_index,     in   (no wait, no read-back)
//                               cfg_data
//
//  One byte is taken per cycle unless full. The front end frames it in the cycle it is
//  accepted and writes a finished frame into a four-entry queue; the back end hands
//  out one result item per cycle unless empty, so a stereo frame takes two pops.
//  full rises only when the queue holds four frames that have not been drained.
//  Reset (rst, synchronous) clears framing, the queue and the back-end phase
//  and loads the config defaults: 16-bit, signed, mono, little endian, no skip.
module raw_pcm_unpacker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  rpu_pkg::in_item_t                   item,
  output logic                                empty,
  input  logic                                pop,
  output rpu_pkg::out_item_t                  result,
  input  logic                                cfg_write,
  input  logic [rpu_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rpu_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rpu_pkg::cfg_t   cfg;
  rpu_pkg::entry_t new_entry;
  rpu_pkg::entry_t head;
  logic            accept;
  logic            new_valid;
  logic            q_full;
  logic            q_empty;
  logic            head_done;

  // Accept a byte whenever the queue has room for the frame it may finish.
  assign full   = q_full;
  assign accept = push & ~q_full;

  // Config registers; indexes outside the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sixteen_bit     <= 1'b1;
      cfg.signed_samples  <= 1'b1;
      cfg.stereo_mode     <= 1'b0;
      cfg.big_endian      <= 1'b0;
      cfg.skip_first_byte <= 1'b0;
    end else if (cfg_write) begin
      unique case (rpu_pkg::cfg_reg_t'(cfg_index))
        rpu_pkg::REG_SIXTEEN_BIT:     cfg.sixteen_bit     <= cfg_data[0];
        rpu_pkg::REG_SIGNED_SAMPLES:  cfg.signed_samples  <= cfg_data[0];
        rpu_pkg::REG_STEREO_MODE:     cfg.stereo_mode     <= cfg_data[0];
        rpu_pkg::REG_BIG_ENDIAN:      cfg.big_endian      <= cfg_data[0];
        rpu_pkg::REG_SKIP_FIRST_BYTE: cfg.skip_first_byte <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Frame bytes and assemble samples.
  rpu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .accept      (accept),
    .item        (item),
    .entry_valid (new_valid),
    .entry       (new_entry)
  );

  // Hold finished frames until the back end drains them.
  rpu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept & new_valid),
    .wr_data (new_entry),
    .rd_en   (head_done),
    .rd_data (head),
    .q_full  (q_full),
    .q_empty (q_empty)
  );

  // Advance through the queued frames one result item per pop.
  rpu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_empty (q_empty),
    .pop        (pop),
    .head_done  (head_done),
    .empty      (empty),
    .result     (result)
  );

endmodule
